// ----- rtl/core/asm_pkg.sv -----
// Shared types and constants for the ARP spoofing table monitor.
// No dependencies; imported by asm_entry_ram, arp_spoof_table_monitor and the test files.
package asm_pkg;

    localparam logic [15:0] ARP_ETHER_TYPE = 16'h0806;
    localparam logic [15:0] MIN_ARP_LENGTH = 16'd42;

    localparam logic [2:0] VERDICT_IGNORED   = 3'd0;
    localparam logic [2:0] VERDICT_LEARNED   = 3'd1;
    localparam logic [2:0] VERDICT_UNCHANGED = 3'd2;
    localparam logic [2:0] VERDICT_FILLED    = 3'd3;
    localparam logic [2:0] VERDICT_SPOOF     = 3'd4;
    localparam logic [2:0] VERDICT_FULL      = 3'd5;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
    } entry_t;

endpackage

// ----- rtl/core/arp_spoof_table_monitor.sv -----
// ARP spoofing monitor: scans a bounded IP-to-MAC table in RAM for each ARP frame.
// Depends on asm_pkg and asm_entry_ram.
//
// channel  dir  handshake          word
// s_       in   s_valid / s_ready  frame_length, ether_type, src_ip, src_mac
// m_       out  m_valid / m_ready  verdict, previous_mac, entries_used
//
// One frame at a time. A non-ARP or short frame skips the lookup and goes straight to output.
// An ARP frame is looked up one RAM read per cycle over the filled entries, at most
// TABLE_DEPTH of them. Entries are filled in order, so the fill count marks the
// valid entries and reset needs no clearing pass.
// A stalled m_ holds the finished word; the next frame is taken meanwhile.
module arp_spoof_table_monitor
    import asm_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_frame_length,
    input  logic [15:0] s_ether_type,
    input  logic [31:0] s_src_ip,
    input  logic [47:0] s_src_mac,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_verdict,
    output logic [47:0] m_previous_mac,
    output logic [6:0]  m_entries_used
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [AW-1:0] pend_idx_reg, pend_idx_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [31:0]   ip_reg, ip_next;
    logic [47:0]   mac_reg, mac_next;
    logic [2:0]    res_verdict_reg, res_verdict_next;
    logic [47:0]   res_prev_reg, res_prev_next;
    logic [6:0]    res_count_reg, res_count_next;
    logic          m_valid_reg, m_valid_next;
    logic [2:0]    m_verdict_reg, m_verdict_next;
    logic [47:0]   m_prev_reg, m_prev_next;
    logic [6:0]    m_count_reg, m_count_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    entry_t        ram_wdata;
    logic [AW-1:0] ram_raddr;
    entry_t        ram_rdata;

    logic          hit;
    logic          s_accept;
    logic          is_arp;

    asm_entry_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign is_arp   = (s_ether_type == ARP_ETHER_TYPE) && (s_frame_length >= MIN_ARP_LENGTH);
    assign hit      = pend_valid_reg && (ram_rdata.ip == ip_reg);

    always_comb begin
        state_next       = state_reg;
        fill_next        = fill_reg;
        idx_next         = idx_reg;
        pend_idx_next    = pend_idx_reg;
        pend_valid_next  = 1'b0;
        ip_next          = ip_reg;
        mac_next         = mac_reg;
        res_verdict_next = res_verdict_reg;
        res_prev_next    = res_prev_reg;
        res_count_next   = res_count_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_verdict_next   = m_verdict_reg;
        m_prev_next      = m_prev_reg;
        m_count_next     = m_count_reg;
        ram_we           = 1'b0;
        ram_waddr        = pend_idx_reg;
        ram_wdata        = '{ip: ip_reg, mac: mac_reg};
        ram_raddr        = idx_reg[AW-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    ip_next  = s_src_ip;
                    mac_next = s_src_mac;
                    idx_next = '0;
                    if (is_arp) begin
                        state_next = ST_SCAN;
                    end else begin
                        res_verdict_next = VERDICT_IGNORED;
                        res_prev_next    = '0;
                        res_count_next   = 7'(fill_reg);
                        state_next       = ST_EMIT;
                    end
                end
            end
            ST_SCAN: begin
                res_prev_next  = '0;
                res_count_next = 7'(fill_reg);
                if (hit) begin
                    state_next = ST_EMIT;
                    if (ram_rdata.mac == '0) begin
                        ram_we           = 1'b1;
                        res_verdict_next = VERDICT_FILLED;
                    end else if (ram_rdata.mac != mac_reg) begin
                        ram_we           = 1'b1;
                        res_verdict_next = VERDICT_SPOOF;
                        res_prev_next    = ram_rdata.mac;
                    end else begin
                        res_verdict_next = VERDICT_UNCHANGED;
                    end
                end else if (idx_reg < fill_reg) begin
                    pend_valid_next = 1'b1;
                    pend_idx_next   = idx_reg[AW-1:0];
                    idx_next        = idx_reg + 1'b1;
                end else begin
                    state_next = ST_EMIT;
                    if (fill_reg == CW'(TABLE_DEPTH)) begin
                        res_verdict_next = VERDICT_FULL;
                    end else begin
                        ram_we           = 1'b1;
                        ram_waddr        = fill_reg[AW-1:0];
                        fill_next        = fill_reg + 1'b1;
                        res_verdict_next = VERDICT_LEARNED;
                        res_count_next   = 7'(fill_reg + 1'b1);
                    end
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_verdict_next = res_verdict_reg;
                    m_prev_next    = res_prev_reg;
                    m_count_next   = res_count_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg         <= idx_next;
        pend_idx_reg    <= pend_idx_next;
        ip_reg          <= ip_next;
        mac_reg         <= mac_next;
        res_verdict_reg <= res_verdict_next;
        res_prev_reg    <= res_prev_next;
        res_count_reg   <= res_count_next;
        m_verdict_reg   <= m_verdict_next;
        m_prev_reg      <= m_prev_next;
        m_count_reg     <= m_count_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_verdict      = m_verdict_reg;
    assign m_previous_mac = m_prev_reg;
    assign m_entries_used = m_count_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_SCAN))
        else $error("entry write outside lookup");

    a_prev_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_verdict_reg != VERDICT_SPOOF)) |-> (m_prev_reg == '0))
        else $error("previous mac set without spoofing verdict");

    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (fill_reg != $past(fill_reg))) |->
            (fill_reg == $past(fill_reg) + 1'b1))
        else $error("fill count moved by more than one");

    a_scan_only_arp: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !is_arp) |=> (state_reg == ST_EMIT))
        else $error("ignored frame entered lookup");

endmodule

// ----- rtl/core/asm_entry_ram.sv -----
// IP-to-MAC entry store: one write port, one read port, registered read data.
// Depends on asm_pkg for entry_t.
module asm_entry_ram
    import asm_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- test/asm_verdict_checker.sv -----
// Checker for arp_spoof_table_monitor: watches both channels, keeps its own
// IP-to-MAC table and compares every verdict word. Depends on asm_pkg.
`timescale 1ns / 100ps

module asm_verdict_checker
    import asm_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [15:0] s_frame_length,
    input  logic [15:0] s_ether_type,
    input  logic [31:0] s_src_ip,
    input  logic [47:0] s_src_mac,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_verdict,
    input  logic [47:0] m_previous_mac,
    input  logic [6:0]  m_entries_used,
    output int          fail_count,
    output int          pending_count,
    output int          checked_count
);

    typedef struct packed {
        logic [2:0]  verdict;
        logic [47:0] prev_mac;
        logic [6:0]  used;
    } verdict_word_t;

    logic [31:0] ip_tab  [TABLE_DEPTH];
    logic [47:0] mac_tab [TABLE_DEPTH];
    int          fill_used;

    verdict_word_t pending_verdicts[$];
    verdict_word_t want;

    initial begin
        fail_count    = 0;
        pending_count = 0;
        checked_count = 0;
        fill_used     = 0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] wanted);
        $display("ERROR: %s at word %0d: got %0h, expected %0h",
                 what, checked_count, got, wanted);
        fail_count++;
    endtask

    // Table lookup and update for one frame.
    function automatic verdict_word_t classify_frame(input logic [15:0] len,
                                                     input logic [15:0] etype,
                                                     input logic [31:0] ip,
                                                     input logic [47:0] mac);
        verdict_word_t w;
        int            hit;
        int            i;
        logic [47:0]   old;
        w.verdict  = VERDICT_IGNORED;
        w.prev_mac = '0;
        hit        = -1;
        if (etype == ARP_ETHER_TYPE && len >= MIN_ARP_LENGTH) begin
            for (i = 0; i < fill_used; i++) begin
                if (hit < 0 && ip_tab[i] == ip) hit = i;
            end
            if (hit >= 0) begin
                old = mac_tab[hit];
                if (old == '0) begin
                    mac_tab[hit] = mac;
                    w.verdict    = VERDICT_FILLED;
                end else if (old != mac) begin
                    mac_tab[hit] = mac;
                    w.verdict    = VERDICT_SPOOF;
                    w.prev_mac   = old;
                end else begin
                    w.verdict = VERDICT_UNCHANGED;
                end
            end else if (fill_used < TABLE_DEPTH) begin
                ip_tab[fill_used]  = ip;
                mac_tab[fill_used] = mac;
                fill_used++;
                w.verdict = VERDICT_LEARNED;
            end else begin
                w.verdict = VERDICT_FULL;
            end
        end
        w.used = fill_used[6:0];
        return w;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            fill_used = 0;
            pending_verdicts.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_verdicts.size() == 0) begin
                    report_mismatch("word with none expected", {61'd0, m_verdict}, 64'd0);
                end else begin
                    want = pending_verdicts.pop_front();
                    if (m_verdict !== want.verdict)
                        report_mismatch("verdict", {61'd0, m_verdict}, {61'd0, want.verdict});
                    if (m_previous_mac !== want.prev_mac)
                        report_mismatch("previous_mac", {16'd0, m_previous_mac},
                                        {16'd0, want.prev_mac});
                    if (m_entries_used !== want.used)
                        report_mismatch("entries_used", {57'd0, m_entries_used},
                                        {57'd0, want.used});
                end
                checked_count++;
            end
            if (s_valid && s_ready)
                pending_verdicts.push_back(classify_frame(s_frame_length, s_ether_type,
                                                          s_src_ip, s_src_mac));
        end
        pending_count = pending_verdicts.size();
    end

endmodule

// ----- test/tb_arp_spoof_table_monitor.sv -----
// Top of the arp_spoof_table_monitor testbench: clock, reset, frame stimulus and
// output back-pressure; verdicts come from asm_verdict_checker. Depends on asm_pkg.
`timescale 1ns / 100ps

module tb_arp_spoof_table_monitor
    import asm_pkg::*;
();

    localparam int TABLE_DEPTH  = 64;
    localparam int POOL_SIZE    = 72;
    localparam int PHASE_FRAMES = 315;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 1000000;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic [15:0] s_frame_length = '0;
    logic [15:0] s_ether_type   = '0;
    logic [31:0] s_src_ip       = '0;
    logic [47:0] s_src_mac      = '0;
    logic        m_ready        = 1'b0;
    wire         s_ready;
    wire         m_valid;
    wire  [2:0]  m_verdict;
    wire  [47:0] m_previous_mac;
    wire  [6:0]  m_entries_used;

    int fail_count;
    int pending_count;
    int checked_count;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_ack       = 0;
    int hold_left      = 0;
    int frames_sent    = 0;
    int arp_frames     = 0;
    int cycle_count    = 0;

    logic [31:0] pool_ip    [POOL_SIZE];
    logic [47:0] pool_mac_a [POOL_SIZE];
    logic [47:0] pool_mac_b [POOL_SIZE];

    arp_spoof_table_monitor #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_frame_length (s_frame_length),
        .s_ether_type   (s_ether_type),
        .s_src_ip       (s_src_ip),
        .s_src_mac      (s_src_mac),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_verdict      (m_verdict),
        .m_previous_mac (m_previous_mac),
        .m_entries_used (m_entries_used)
    );

    asm_verdict_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_frame_length (s_frame_length),
        .s_ether_type   (s_ether_type),
        .s_src_ip       (s_src_ip),
        .s_src_mac      (s_src_mac),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_verdict      (m_verdict),
        .m_previous_mac (m_previous_mac),
        .m_entries_used (m_entries_used),
        .fail_count     (fail_count),
        .pending_count  (pending_count),
        .checked_count  (checked_count)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, pending_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // output back-pressure; a hold-off request blocks m_ready for a fixed stretch
    always @(negedge aclk) begin
        if (hold_ack != hold_req) begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready   = 1'b0;
        end else begin
            m_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [47:0] rand_mac();
        logic [63:0] t;
        t = {$urandom, $urandom};
        return t[47:0];
    endfunction

    task automatic send_frame(input logic [15:0] len, input logic [15:0] etype,
                              input logic [31:0] ip, input logic [47:0] mac);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid        = 1'b1;
        s_frame_length = len;
        s_ether_type   = etype;
        s_src_ip       = ip;
        s_src_mac      = mac;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        frames_sent++;
    endtask

    // mostly ARP from a small IP pool with a few MACs each, some noise frames
    task automatic send_random_frame();
        int          k;
        int          pick;
        logic [15:0] len;
        logic [15:0] etype;
        logic [31:0] ip;
        logic [47:0] mac;
        k  = $urandom_range(POOL_SIZE - 1);
        ip = pool_ip[k];
        if ($urandom_range(99) < 5) ip = $urandom;
        pick = $urandom_range(99);
        if (pick < 45)      mac = pool_mac_a[k];
        else if (pick < 70) mac = pool_mac_b[k];
        else if (pick < 80) mac = '0;
        else                mac = rand_mac();
        etype = ARP_ETHER_TYPE;
        if ($urandom_range(4) == 0) len = 16'($urandom_range(65535, 42));
        else                        len = 16'($urandom_range(1518, 42));
        pick = $urandom_range(99);
        if (pick < 4) begin
            etype = 16'($urandom);
        end else if (pick < 8) begin
            len = 16'($urandom_range(41));
        end else if (pick < 12) begin
            etype = 16'($urandom);
            len   = 16'($urandom);
        end else begin
            arp_frames++;
        end
        send_frame(len, etype, ip, mac);
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (pending_count != 0) @(negedge aclk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        int target;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target         = arp_frames + PHASE_FRAMES;
        while (arp_frames < target) send_random_frame();
    endtask

    initial begin
        int k;
        for (k = 0; k < POOL_SIZE; k++) begin
            pool_ip[k]    = $urandom;
            pool_mac_a[k] = rand_mac();
            pool_mac_b[k] = rand_mac();
        end

        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: length and type edges, zero MAC learn/fill, spoof, ignore
        send_frame(16'd0,     ARP_ETHER_TYPE, 32'h0000_0001, 48'h0000_0000_0001);
        send_frame(16'd41,    ARP_ETHER_TYPE, 32'h0000_0001, 48'h0000_0000_0001);
        send_frame(16'hFFFF,  16'hFFFF,       32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_frame(16'd42,    16'h0000,       32'h0000_0000, 48'h0000_0000_0000);
        send_frame(16'd42,    16'h0608,       32'h0000_0000, 48'h0000_0000_0000);
        send_frame(16'd42,    ARP_ETHER_TYPE, 32'h0000_0000, 48'h0000_0000_0000);
        send_frame(16'd60,    ARP_ETHER_TYPE, 32'h0000_0000, 48'h0000_0000_0000);
        send_frame(16'd60,    ARP_ETHER_TYPE, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
        send_frame(16'd60,    ARP_ETHER_TYPE, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
        send_frame(16'd60,    ARP_ETHER_TYPE, 32'h0000_0000, 48'h0000_0000_0001);
        send_frame(16'hFFFF,  ARP_ETHER_TYPE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_frame(16'd42,    ARP_ETHER_TYPE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_frame(16'd42,    ARP_ETHER_TYPE, 32'hFFFF_FFFF, 48'h0000_0000_0000);
        send_frame(16'd42,    ARP_ETHER_TYPE, 32'hFFFF_FFFF, 48'hA5A5_5A5A_A5A5);
        send_frame(16'd41,    ARP_ETHER_TYPE, 32'h0000_0000, 48'h1234_5678_9ABC);
        send_frame(16'd1518,  16'h0800,       32'h0000_0000, 48'h1234_5678_9ABC);
        send_frame(16'd60,    ARP_ETHER_TYPE, 32'h0000_0000, 48'h0000_0000_0001);
        send_frame(16'd1518,  ARP_ETHER_TYPE, 32'h0A00_0001, 48'h0200_0000_0001);
        send_frame(16'd1518,  ARP_ETHER_TYPE, 32'h0A00_0001, 48'h0200_0000_0002);
        send_frame(16'd43,    ARP_ETHER_TYPE, 32'h0A00_0001, 48'h0200_0000_0002);
        wait_drained();

        // long output hold-off while frames keep coming
        hold_req++;
        run_phase(0, 0);
        wait_drained();
        run_phase(52, 0);
        run_phase(0, 52);
        wait_drained();
        run_phase(35, 35);

        wait_drained();
        repeat (TABLE_DEPTH + 8) @(negedge aclk);

        $display("Summary: %0d frames sent (%0d ARP in random phases), %0d words checked",
                 frames_sent, arp_frames, checked_count);
        $display("Summary: free-running, sender-idle, receiver-stall and mixed phases, %0d%s",
                 HOLD_CYCLES, "-cycle hold-off");
        if (fail_count == 0 && pending_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
